FILE: src/wsd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SKIP    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_OK       = 3'd1,
    ST_SHORT    = 3'd2,
    ST_CONTROL  = 3'd3,
    ST_BADOP    = 3'd4,
    ST_UNMASKED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    LEN_7  = 2'd0,
    LEN_16 = 2'd1,
    LEN_64 = 2'd2
  } len_kind_t;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN16_CODE = 7'd126;
  localparam logic [6:0] LEN64_CODE = 7'd127;
  localparam int unsigned MASK_BIT  = 7;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

endpackage

FILE: src/wsd_ifs.sv
// Valid/ready channel interfaces for the deframer's byte input and result output.
interface wsd_in_if import wsd_pkg::*; (input logic clk);
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_end;

  modport source (output valid, data_byte, chunk_end, input ready);
  modport sink   (input valid, data_byte, chunk_end, output ready);
endinterface

interface wsd_out_if import wsd_pkg::*; (input logic clk);
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       msg_last;
  status_t    status;

  modport source (output valid, out_valid, out_byte, msg_last, status, input ready);
  modport sink   (input valid, out_valid, out_byte, msg_last, status, output ready);
endinterface

FILE: src/websocket_frame_deframer.sv
// Top level: byte-serial WebSocket frame parser and payload unmasker.
//
//  channel   | dir | payload                                  | handshake
//  in_ch     | in  | data_byte[7:0], chunk_end                | valid/ready
//  out_ch    | out | out_valid, out_byte[7:0], msg_last,      | valid/ready
//            |     | status[2:0]                              |
//
// One byte per cycle sustained while out_ch is not stalled; a result is made as
// its byte passes the input register, then the result register. The parser
// state advances once per byte as it moves from the input register into the
// result register. Synchronous active-low reset empties both registers and
// puts the parser on the first header byte. A stalled output holds the result;
// an empty input register still takes one more byte while the result waits.
module websocket_frame_deframer import wsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  wsd_in_if.sink     in_ch,
  wsd_out_if.source  out_ch
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // result register
  logic       res_vld_r;
  logic       res_bvalid_r;
  logic [7:0] res_byte_r;
  logic       res_mlast_r;
  status_t    res_status_r;

  // parser state
  phase_t     phase_r, phase_nxt;
  logic [3:0] field_index_r, field_index_nxt;
  len_kind_t  wide_length_r, wide_length_nxt;
  logic       is_masked_r, is_masked_nxt;
  logic [63:0] remaining_r, remaining_nxt;
  logic [31:0] mask_key_r, mask_key_nxt;
  logic [1:0] key_pos_r, key_pos_nxt;

  logic       advance;
  logic       s1_fire;
  logic [3:0] fi_inc;
  logic [3:0] ext_need;
  logic [3:0] opcode;
  logic [6:0] len7;
  logic [7:0] key_byte;

  logic       decided;
  logic       r_bvalid;
  logic [7:0] r_byte;
  logic       r_mlast;
  status_t    r_status;

  assign advance     = !res_vld_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;

  assign fi_inc   = field_index_r + 4'd1;
  assign ext_need = (wide_length_r == LEN_16) ? EXT16_BYTES : EXT64_BYTES;
  assign opcode   = s1_byte_r[3:0];
  assign len7     = s1_byte_r[6:0];

  always_comb begin
    case (key_pos_r)
      2'd0:    key_byte = mask_key_r[31:24];
      2'd1:    key_byte = mask_key_r[23:16];
      2'd2:    key_byte = mask_key_r[15:8];
      default: key_byte = mask_key_r[7:0];
    endcase
  end

  // result of the byte in the input register
  always_comb begin
    decided  = 1'b0;
    r_bvalid = 1'b0;
    r_byte   = 8'd0;
    r_mlast  = 1'b0;
    r_status = ST_BUSY;
    case (phase_r)
      PH_HDR0: begin
        if (!s1_last_r) begin
          if (opcode inside {OP_CLOSE, OP_PING, OP_PONG}) begin
            r_status = ST_CONTROL;
            decided  = 1'b1;
          end else if (!(opcode inside {OP_CONT, OP_TEXT})) begin
            r_status = ST_BADOP;
            decided  = 1'b1;
          end
        end
      end
      PH_HDR1: begin
        if (len7 != LEN16_CODE && len7 != LEN64_CODE && !s1_byte_r[MASK_BIT]) begin
          r_status = ST_UNMASKED;
          decided  = 1'b1;
        end
      end
      PH_EXTLEN: begin
        if (fi_inc >= ext_need && !is_masked_r) begin
          r_status = ST_UNMASKED;
          decided  = 1'b1;
        end
      end
      PH_KEY: begin
        if (fi_inc >= KEY_BYTES && remaining_r == 64'd0) begin
          r_status = ST_OK;
          r_mlast  = 1'b1;
          decided  = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        r_bvalid = 1'b1;
        r_byte   = s1_byte_r ^ key_byte;
        // this byte is the last one of the payload
        if (remaining_r == 64'd1) begin
          r_status = ST_OK;
          r_mlast  = 1'b1;
          decided  = 1'b1;
        end
      end
      default: decided = 1'b1;
    endcase
    if (s1_last_r && !decided) r_status = ST_SHORT;
  end

  // parser next state
  always_comb begin
    phase_nxt       = phase_r;
    field_index_nxt = field_index_r;
    wide_length_nxt = wide_length_r;
    is_masked_nxt   = is_masked_r;
    remaining_nxt   = remaining_r;
    mask_key_nxt    = mask_key_r;
    key_pos_nxt     = key_pos_r;
    case (phase_r)
      PH_HDR0: phase_nxt = PH_HDR1;
      PH_HDR1: begin
        is_masked_nxt   = s1_byte_r[MASK_BIT];
        field_index_nxt = 4'd0;
        remaining_nxt   = 64'd0;
        if (len7 == LEN16_CODE) begin
          wide_length_nxt = LEN_16;
          phase_nxt       = PH_EXTLEN;
        end else if (len7 == LEN64_CODE) begin
          wide_length_nxt = LEN_64;
          phase_nxt       = PH_EXTLEN;
        end else begin
          wide_length_nxt = LEN_7;
          remaining_nxt   = {57'd0, len7};
          if (s1_byte_r[MASK_BIT]) phase_nxt = PH_KEY;
        end
      end
      PH_EXTLEN: begin
        remaining_nxt   = {remaining_r[55:0], s1_byte_r};
        field_index_nxt = fi_inc;
        if (fi_inc >= ext_need) begin
          field_index_nxt = 4'd0;
          if (is_masked_r) phase_nxt = PH_KEY;
        end
      end
      PH_KEY: begin
        mask_key_nxt    = {mask_key_r[23:0], s1_byte_r};
        field_index_nxt = fi_inc;
        if (fi_inc >= KEY_BYTES) begin
          field_index_nxt = 4'd0;
          key_pos_nxt     = 2'd0;
          if (remaining_r != 64'd0) phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        key_pos_nxt   = key_pos_r + 2'd1;
        remaining_nxt = remaining_r - 64'd1;
      end
      default: phase_nxt = PH_SKIP;
    endcase
    if (decided) phase_nxt = PH_SKIP;
    // a chunk end always restarts at the first header byte
    if (s1_last_r) begin
      phase_nxt       = PH_HDR0;
      field_index_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      res_vld_r     <= 1'b0;
      phase_r       <= PH_HDR0;
      field_index_r <= 4'd0;
      wide_length_r <= LEN_7;
      is_masked_r   <= 1'b0;
      remaining_r   <= 64'd0;
      mask_key_r    <= 32'd0;
      key_pos_r     <= 2'd0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (advance) res_vld_r <= s1_valid_r;
      if (s1_fire) begin
        phase_r       <= phase_nxt;
        field_index_r <= field_index_nxt;
        wide_length_r <= wide_length_nxt;
        is_masked_r   <= is_masked_nxt;
        remaining_r   <= remaining_nxt;
        mask_key_r    <= mask_key_nxt;
        key_pos_r     <= key_pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.chunk_end;
    end
    if (s1_fire) begin
      res_bvalid_r <= r_bvalid;
      res_byte_r   <= r_byte;
      res_mlast_r  <= r_mlast;
      res_status_r <= r_status;
    end
  end

  assign out_ch.valid     = res_vld_r;
  assign out_ch.out_valid = res_bvalid_r;
  assign out_ch.out_byte  = res_byte_r;
  assign out_ch.msg_last  = res_mlast_r;
  assign out_ch.status    = res_status_r;

endmodule

FILE: src/wsd_checker.sv
// Port-level assertions for the deframer, bound to the top level.
module wsd_checker import wsd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_vld,
  input logic       out_rdy,
  input logic       out_valid,
  input logic [7:0] out_byte,
  input logic       msg_last,
  input logic [2:0] status
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_rdy |=> out_vld && $stable(out_byte) && $stable(status)
      && $stable(msg_last) && $stable(out_valid))
    else $error("result changed while stalled");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_valid |-> out_byte == 8'd0)
    else $error("payload byte set without out_valid");

  a_last_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && msg_last |-> status == ST_OK)
    else $error("msg_last without ok status");

  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_valid |-> status == ST_BUSY || status == ST_OK || status == ST_SHORT)
    else $error("payload byte carries a drop status");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> status <= ST_UNMASKED)
    else $error("status code out of range");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_vld   (out_ch.valid),
  .out_rdy   (out_ch.ready),
  .out_valid (out_ch.out_valid),
  .out_byte  (out_ch.out_byte),
  .msg_last  (out_ch.msg_last),
  .status    (out_ch.status)
);
